/* rtl/dq_pkg.sv */
// Shared constants, command and status codes, and the cell control type of the deque.
package dq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int DEFAULT_WORD_BITS   = 32;

   localparam int COMMAND_BITS = 3;
   localparam int VALUE_BITS   = 32;
   localparam int STATUS_BITS  = 2;

   localparam logic [COMMAND_BITS-1:0] CMD_PUSH_HEAD = 3'd0;
   localparam logic [COMMAND_BITS-1:0] CMD_PUSH_TAIL = 3'd1;
   localparam logic [COMMAND_BITS-1:0] CMD_POP_HEAD  = 3'd2;
   localparam logic [COMMAND_BITS-1:0] CMD_POP_TAIL  = 3'd3;
   localparam logic [COMMAND_BITS-1:0] CMD_REPORT    = 3'd4;

   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW  = 2'd2;

   typedef struct packed {
      logic push_head;
      logic push_tail;
      logic pop_head;
      logic pop_tail;
   } cell_ctl_type;

endpackage

/* rtl/dq_if.sv */
// Valid/ready channel interfaces for the deque commands and results.
interface dq_req_if import dq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [COMMAND_BITS-1:0] command;
   logic [VALUE_BITS-1:0]   push_value;

   modport source (output valid, output command, output push_value, input ready);
   modport sink (input valid, input command, input push_value, output ready);
endinterface

interface dq_rsp_if import dq_pkg::*; #(
   parameter int COUNT_BITS = $clog2(DEFAULT_QUEUE_DEPTH + 1)
) ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [VALUE_BITS-1:0]  popped_value;
   logic [COUNT_BITS-1:0]  entry_count;

   modport source (output valid, output status, output popped_value, output entry_count,
                   input ready);
   modport sink (input valid, input status, input popped_value, input entry_count,
                 output ready);
endinterface

/* rtl/dq_cell.sv */
// One storage cell of the deque row, shifting with its neighbors on head operations.
module dq_cell import dq_pkg::*; #(
   parameter int DATA_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctl_type         ctl,
   input  logic [DATA_BITS-1:0] new_data,
   input  logic [DATA_BITS-1:0] left_data,
   input  logic                 left_occ,
   input  logic [DATA_BITS-1:0] right_data,
   input  logic                 right_occ,
   output logic [DATA_BITS-1:0] data,
   output logic                 occ,
   output logic                 is_tail
);

   logic [DATA_BITS-1:0] data_ff, data_in;
   logic                 occ_ff, occ_in;

   assign is_tail = occ_ff && !right_occ;

   always_comb begin
      data_in = data_ff;
      occ_in  = occ_ff;
      if (ctl.push_head) begin
         data_in = left_data;
         occ_in  = left_occ;
      end else if (ctl.pop_head) begin
         data_in = right_data;
         occ_in  = right_occ;
      end else if (ctl.push_tail) begin
         if (!occ_ff && left_occ) begin
            data_in = new_data;
            occ_in  = 1'b1;
         end
      end else if (ctl.pop_tail) begin
         if (is_tail) begin
            occ_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign data = data_ff;
   assign occ  = occ_ff;

endmodule

/* rtl/double_ended_queue.sv */
// Top level of the bounded double-ended queue built from a row of shifting cells.
//
// Commands arrive on req_bus (push head, push tail, pop head, pop tail, report)
// and each one produces exactly one result on rsp_bus: a status, the popped word
// and the number of stored words after the command.
// Cell 0 always holds the head word; a head push or pop shifts the whole row by one
// cell, while a tail push or pop touches only the cell at the end of the occupied run.
// A command's result is registered and shows from the cycle after its transfer on, and
// one command is taken in every cycle while results drain.
// The tail pop reads through a one-hot select across all cells into the result register.
// Reset empties the queue by clearing the occupancy flags and the count; stored words
// keep whatever they held. When the receiver stalls, the result register holds and
// req_bus.ready stays low until that result has been transferred.
module double_ended_queue import dq_pkg::*; #(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   parameter int WORD_BITS   = DEFAULT_WORD_BITS
) (
   input logic     clock,
   input logic     reset,
   dq_req_if.sink   req_bus,
   dq_rsp_if.source rsp_bus
);

   localparam int CELL_BITS  = (WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [CELL_BITS-1:0]  cell_data [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_occ;
   logic [QUEUE_DEPTH-1:0] cell_tail;
   logic [CELL_BITS-1:0]  new_data;
   logic [CELL_BITS-1:0]  tail_word;
   cell_ctl_type          ctl;

   logic                   accept, empty, full;
   logic [STATUS_BITS-1:0] status_calc;
   logic [CELL_BITS-1:0]   pop_word;
   logic                   do_push, do_pop;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [VALUE_BITS-1:0]  popped_ff, popped_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [COUNT_BITS-1:0]  rsp_count_ff;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign empty         = !cell_occ[0];
   assign full          = cell_occ[QUEUE_DEPTH-1];
   assign new_data      = req_bus.push_value[CELL_BITS-1:0];

   always_comb begin
      ctl         = '0;
      status_calc = STATUS_OK;
      pop_word    = '0;
      unique case (req_bus.command)
         CMD_PUSH_HEAD: begin
            if (full) status_calc = STATUS_OVERFLOW;
            else ctl.push_head = accept;
         end
         CMD_PUSH_TAIL: begin
            if (full) status_calc = STATUS_OVERFLOW;
            else ctl.push_tail = accept;
         end
         CMD_POP_HEAD: begin
            if (empty) begin
               status_calc = STATUS_UNDERFLOW;
            end else begin
               ctl.pop_head = accept;
               pop_word     = cell_data[0];
            end
         end
         CMD_POP_TAIL: begin
            if (empty) begin
               status_calc = STATUS_UNDERFLOW;
            end else begin
               ctl.pop_tail = accept;
               pop_word     = tail_word;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      tail_word = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         tail_word = tail_word | (cell_data[i] & {CELL_BITS{cell_tail[i]}});
      end
   end

   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         logic [CELL_BITS-1:0] left_data, right_data;
         logic                 left_occ, right_occ;
         if (g == 0) begin : g_first
            assign left_data = new_data;
            assign left_occ  = 1'b1;
         end else begin : g_mid_left
            assign left_data = cell_data[g-1];
            assign left_occ  = cell_occ[g-1];
         end
         if (g == QUEUE_DEPTH - 1) begin : g_last
            assign right_data = '0;
            assign right_occ  = 1'b0;
         end else begin : g_mid_right
            assign right_data = cell_data[g+1];
            assign right_occ  = cell_occ[g+1];
         end
         dq_cell #(.DATA_BITS(CELL_BITS)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .new_data   (new_data),
            .left_data  (left_data),
            .left_occ   (left_occ),
            .right_data (right_data),
            .right_occ  (right_occ),
            .data       (cell_data[g]),
            .occ        (cell_occ[g]),
            .is_tail    (cell_tail[g])
         );
      end
   endgenerate

   assign do_push = ctl.push_head || ctl.push_tail;
   assign do_pop  = ctl.pop_head || ctl.pop_tail;

   always_comb begin
      count_in = count_ff;
      if (do_push) count_in = count_ff + COUNT_BITS'(1);
      else if (do_pop) count_in = count_ff - COUNT_BITS'(1);
      popped_in                = '0;
      popped_in[CELL_BITS-1:0] = pop_word;
      status_in                = status_calc;
      rsp_valid_in = accept ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         popped_ff    <= popped_in;
         rsp_count_ff <= count_in;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.popped_value = popped_ff;
   assign rsp_bus.entry_count  = rsp_count_ff;

endmodule

/* rtl/dq_checker.sv */
// Port-level assertions for the deque and the bind that attaches them to the top level.
module dq_checker import dq_pkg::*; #(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   parameter int COUNT_BITS  = $clog2(DEFAULT_QUEUE_DEPTH + 1)
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [STATUS_BITS-1:0] rsp_status,
   input logic [VALUE_BITS-1:0]  rsp_popped_value,
   input logic [COUNT_BITS-1:0]  rsp_entry_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Result dropped before its transfer.");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("Command transfer produced no result.");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("Command taken while a result was stalled.");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_UNDERFLOW || rsp_status == STATUS_OVERFLOW)
      |-> rsp_popped_value == '0)
      else $error("Failed command returned a nonzero word.");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= COUNT_BITS'(QUEUE_DEPTH)) &&
                    (rsp_status != STATUS_UNDERFLOW || rsp_entry_count == '0) &&
                    (rsp_status != STATUS_OVERFLOW ||
                     rsp_entry_count == COUNT_BITS'(QUEUE_DEPTH)))
      else $error("Entry count inconsistent with status.");

endmodule

bind double_ended_queue dq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH),
   .COUNT_BITS  (COUNT_BITS)
) u_dq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_status       (rsp_bus.status),
   .rsp_popped_value (rsp_bus.popped_value),
   .rsp_entry_count  (rsp_bus.entry_count)
);
